>>> design/ffba_pkg.sv
// ffba_pkg: shared types, state codes and status codes for the first-fit allocator
// no dependencies
`default_nettype none
package ffba_pkg;
   typedef struct packed {
      logic        kind;
      logic [20:0] request_bytes;
      logic [19:0] user_address;
   } req_type;

   typedef struct packed {
      logic [19:0] granted_address;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ZERO    = 2'd1,
      ST_NOMEM   = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_AWALK,
      S_AWAIT,
      S_GROW,
      S_SPLIT,
      S_FWALK,
      S_FWAIT,
      S_MREAD,
      S_MWAIT,
      S_MCHECK,
      S_LINKTAIL,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

>>> design/first_fit_block_allocator.sv
// First-fit allocator: one request at a time. Allocations and frees walk the block chain in the
// slot RAM (at most MAX_SLOTS blocks; each is read, then compared), then update the chain.
// The free-slot search runs combinationally over a bit vector of in-use flags.
// Depends on ffba_pkg and ffba_ram.
`default_nettype none
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAX_SLOTS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   localparam int SW = $clog2(MAX_SLOTS);
   localparam int LW = SW + 1;
   localparam int EW = 20 + 21 + 1 + LW;
   localparam logic [LW-1:0] NO_LINK = LW'(MAX_SLOTS);
   localparam logic [21:0] POOL = 22'd1048576;
   localparam logic [21:0] HDR = 22'd24;
   localparam logic [21:0] MINB = 22'd32;

   typedef struct packed {
      logic [19:0]   start;
      logic [20:0]   bytes;
      logic          free;
      logic [LW-1:0] link;
   } ent_type;

   state_type state_ff, state_in;
   req_type req_ff;
   logic [MAX_SLOTS-1:0] inuse_ff, inuse_in;
   logic [SW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [20:0] top_ff, top_in;
   logic started_ff, started_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [SW-1:0] b_ff, b_in;
   logic [SW:0] steps_ff, steps_in;
   logic [21:0] total_ff, total_in;
   ent_type bent_ff, bent_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic we;
   logic [SW-1:0] ra;
   ent_type wd, rd;

   ffba_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_slots (
      .clock(clock), .wr_en(we), .addr(ra), .wr_data(wd), .rd_data(rd)
   );

   logic [LW-1:0] grab;
   always_comb begin
      grab = NO_LINK;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (!inuse_ff[i]) grab = LW'(i);
      end
   end

   logic [21:0] grow;
   assign grow = (total_ff + 22'd4095) & ~22'd4095;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         inuse_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         top_ff <= '0;
         started_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         inuse_ff <= inuse_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         top_ff <= top_in;
         started_ff <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= (req_valid && req_ready) ? req_data : req_ff;
      cur_ff <= cur_in;
      b_ff <= b_in;
      steps_ff <= steps_in;
      total_ff <= total_in;
      bent_ff <= bent_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      inuse_in = inuse_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      top_in = top_ff;
      started_in = started_ff;
      cur_in = cur_ff;
      b_in = b_ff;
      steps_in = steps_ff;
      total_in = total_ff;
      bent_in = bent_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      we = 1'b0;
      ra = cur_ff[SW-1:0];
      wd = bent_ff;
      req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_in.granted_address = '0;
               rsp_in.status = ST_OK;
               cur_in = {1'b0, head_ff};
               steps_in = '0;
               total_in = {1'b0, req_data.request_bytes} + HDR;
               if (total_in < MINB) total_in = MINB;
               if (req_data.kind == KIND_ALLOC) begin
                  if (req_data.request_bytes == '0) begin
                     rsp_in.status = ST_ZERO;
                     state_in = S_DONE;
                  end else begin
                     state_in = started_ff ? S_AWALK : S_GROW;
                  end
               end else if (req_data.user_address == '0) begin
                  state_in = S_DONE;
               end else if (!started_ff) begin
                  rsp_in.status = ST_UNKNOWN;
                  state_in = S_DONE;
               end else begin
                  state_in = S_FWALK;
               end
            end
         end
         S_AWALK, S_FWALK: begin
            if (steps_ff == (SW+1)'(MAX_SLOTS) || cur_ff >= NO_LINK) begin
               if (state_ff == S_AWALK) begin
                  state_in = S_GROW;
               end else begin
                  rsp_in.status = ST_UNKNOWN;
                  state_in = S_DONE;
               end
            end else begin
               state_in = (state_ff == S_AWALK) ? S_AWAIT : S_FWAIT;
            end
         end
         S_AWAIT: begin
            if (rd.free && {1'b0, rd.bytes} >= total_ff) begin
               b_in = cur_ff[SW-1:0];
               bent_in = rd;
               state_in = S_SPLIT;
            end else begin
               cur_in = rd.link;
               steps_in = steps_ff + 1'b1;
               state_in = S_AWALK;
            end
         end
         S_GROW: begin
            if ({1'b0, top_ff} + grow > POOL || grab == NO_LINK) begin
               rsp_in.status = ST_NOMEM;
               state_in = S_DONE;
            end else begin
               b_in = grab[SW-1:0];
               inuse_in[grab[SW-1:0]] = 1'b1;
               bent_in.start = top_ff[19:0];
               bent_in.bytes = grow[20:0];
               bent_in.free = 1'b1;
               bent_in.link = NO_LINK;
               top_in = top_ff + grow[20:0];
               if (started_ff) begin
                  cur_in = {1'b0, tail_ff};
                  steps_in = '0;
                  state_in = S_LINKTAIL;
               end else begin
                  head_in = grab[SW-1:0];
                  started_in = 1'b1;
                  state_in = S_SPLIT;
               end
               tail_in = grab[SW-1:0];
            end
         end
         S_LINKTAIL: begin
            // tail entry still latched in ram read data from last walk is not reliable
            // so read-modify-write: issue the read first while cur_ff holds tail, then write it back
            if (steps_ff[0] == 1'b0 || state_ff != S_LINKTAIL) begin
               steps_in = '1;
            end
            state_in = S_LINKTAIL;
            if (steps_ff == '1) begin
               we = 1'b1;
               wd = rd;
               wd.link = {1'b0, b_ff};
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            ra = b_ff;
            we = 1'b1;
            wd = bent_ff;
            wd.free = 1'b0;
            rsp_in.granted_address = bent_ff.start + 20'(HDR);
            rsp_in.status = ST_OK;
            state_in = S_DONE;
            if ({1'b0, bent_ff.bytes} >= total_ff + MINB && grab != NO_LINK) begin
               wd.bytes = total_ff[20:0];
               wd.link = grab;
               inuse_in[grab[SW-1:0]] = 1'b1;
               if (tail_ff == b_ff) tail_in = grab[SW-1:0];
               bent_in.start = bent_ff.start + total_ff[19:0];
               bent_in.bytes = bent_ff.bytes - total_ff[20:0];
               bent_in.free = 1'b1;
               bent_in.link = bent_ff.link;
               cur_in = grab;
               state_in = S_MCHECK;
               steps_in = '0;
            end
         end
         S_MCHECK: begin
            // write the split remainder or merged free block, or read the next block to merge
            ra = cur_ff[SW-1:0];
            we = 1'b1;
            wd = bent_ff;
            state_in = S_DONE;
            if (req_ff.kind == KIND_FREE && bent_ff.link < NO_LINK
                && steps_ff != (SW+1)'(MAX_SLOTS)) begin
               we = 1'b0;
               ra = bent_ff.link[SW-1:0];
               state_in = S_MWAIT;
            end
         end
         S_FWAIT: begin
            if ({2'b0, rd.start} + HDR == {2'b0, req_ff.user_address}) begin
               bent_in = rd;
               bent_in.free = 1'b1;
               b_in = cur_ff[SW-1:0];
               steps_in = '0;
               state_in = S_MCHECK;
            end else begin
               cur_in = rd.link;
               steps_in = steps_ff + 1'b1;
               state_in = S_FWALK;
            end
         end
         S_MREAD: state_in = S_MWAIT;
         S_MWAIT: begin
            ra = bent_ff.link[SW-1:0];
            if (rd.free && ({1'b0, bent_ff.start} + {1'b0, bent_ff.bytes})
                == {2'b0, rd.start}) begin
               bent_in.bytes = bent_ff.bytes + rd.bytes;
               bent_in.link = rd.link;
               inuse_in[bent_ff.link[SW-1:0]] = 1'b0;
               if (tail_ff == bent_ff.link[SW-1:0]) tail_in = b_ff;
               steps_in = steps_ff + 1'b1;
               state_in = S_MCHECK;
            end else begin
               ra = b_ff;
               we = 1'b1;
               wd = bent_ff;
               state_in = S_DONE;
            end
            cur_in = {1'b0, b_ff};
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_LINKTAIL) ra = cur_ff[SW-1:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("request taken while response pending");
   a_status_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> rsp_data.granted_address == '0)
      else $error("address on failed response");
   a_started: assert property (@(posedge clock) disable iff (reset)
      $fell(started_ff) |-> 1'b0)
      else $error("heap start lost");
endmodule
`default_nettype wire

>>> design/ffba_ram.sv
// ffba_ram: generic single-port synchronous RAM with registered read
// no dependencies
`default_nettype none
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

>>> tb/ffba_checker.sv
// ffba_checker: watches the request and response channels of the first-fit allocator,
// predicts each response from its own copy of the block chain and compares them
// depends on ffba_pkg
`timescale 1ns / 100ps
`default_nettype none
module ffba_checker
   import ffba_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);
   localparam int SLOTS = 64;
   localparam int HDR = 24;
   localparam int MINB = 32;
   localparam int PAGE = 4096;
   localparam int POOL = 1048576;

   logic [19:0] blk_start [SLOTS];
   logic [20:0] blk_bytes [SLOTS];
   logic        blk_free [SLOTS];
   int          blk_next [SLOTS];
   logic        blk_used [SLOTS];
   int          head_idx, tail_idx;
   longint      top_bytes;
   logic        started;
   rsp_type     expected_rsp [$];

   function automatic int find_slot();
      for (int i = 0; i < SLOTS; i++) begin
         if (!blk_used[i]) return i;
      end
      return SLOTS;
   endfunction

   function automatic void merge_after(int b);
      int n;
      for (int s = 0; s < SLOTS; s++) begin
         n = blk_next[b];
         if (n >= SLOTS || !blk_free[b] || !blk_free[n]) return;
         if (longint'(blk_start[b]) + blk_bytes[b] != longint'(blk_start[n])) return;
         blk_bytes[b] = blk_bytes[b] + blk_bytes[n];
         blk_next[b] = blk_next[n];
         blk_used[n] = 1'b0;
         if (tail_idx == n) tail_idx = b;
      end
   endfunction

   function automatic rsp_type allocate(longint req);
      rsp_type r;
      longint need, grow;
      int cur, b, ns;
      r = '0;
      b = SLOTS;
      if (req == 0) begin
         r.status = ST_ZERO;
         return r;
      end
      need = req + HDR;
      if (need < MINB) need = MINB;
      if (started) begin
         cur = head_idx;
         for (int s = 0; s < SLOTS && cur < SLOTS; s++) begin
            if (blk_free[cur] && blk_bytes[cur] >= need) begin
               b = cur;
               break;
            end
            cur = blk_next[cur];
         end
      end
      if (b == SLOTS) begin
         grow = ((need + PAGE - 1) / PAGE) * PAGE;
         b = find_slot();
         if (top_bytes + grow > POOL || b == SLOTS) begin
            r.status = ST_NOMEM;
            return r;
         end
         blk_used[b] = 1'b1;
         blk_start[b] = top_bytes[19:0];
         blk_bytes[b] = grow[20:0];
         blk_free[b] = 1'b1;
         blk_next[b] = SLOTS;
         top_bytes = (top_bytes + grow) & 64'h1FFFFF;
         if (started) blk_next[tail_idx] = b;
         else begin
            head_idx = b;
            started = 1'b1;
         end
         tail_idx = b;
      end
      if (longint'(blk_bytes[b]) >= need + MINB) begin
         ns = find_slot();
         if (ns != SLOTS) begin
            blk_used[ns] = 1'b1;
            blk_start[ns] = blk_start[b] + need[19:0];
            blk_bytes[ns] = blk_bytes[b] - need[20:0];
            blk_free[ns] = 1'b1;
            blk_next[ns] = blk_next[b];
            blk_bytes[b] = need[20:0];
            blk_next[b] = ns;
            if (tail_idx == b) tail_idx = ns;
         end
      end
      blk_free[b] = 1'b0;
      r.granted_address = blk_start[b] + 20'(HDR);
      r.status = ST_OK;
      return r;
   endfunction

   function automatic rsp_type release_block(logic [19:0] ua);
      rsp_type r;
      int cur;
      r = '0;
      if (ua == 0) return r;
      r.status = ST_UNKNOWN;
      if (!started) return r;
      cur = head_idx;
      for (int s = 0; s < SLOTS && cur < SLOTS; s++) begin
         if (longint'(blk_start[cur]) + HDR == longint'(ua)) begin
            blk_free[cur] = 1'b1;
            merge_after(cur);
            r.status = ST_OK;
            return r;
         end
         cur = blk_next[cur];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   assign pending_count = expected_rsp.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) blk_used[i] = 1'b0;
         head_idx = 0;
         tail_idx = 0;
         top_bytes = 0;
         started = 1'b0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) report_mismatch("response with none expected");
            else begin
               exp_rsp = expected_rsp.pop_front();
               if (rsp_data.granted_address !== exp_rsp.granted_address)
                  report_mismatch($sformatf("granted_address got %0h want %0h",
                     rsp_data.granted_address, exp_rsp.granted_address));
               if (rsp_data.status !== exp_rsp.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                     rsp_data.status, exp_rsp.status));
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.kind == KIND_ALLOC)
               expected_rsp.push_back(allocate(longint'(req_data.request_bytes)));
            else
               expected_rsp.push_back(release_block(req_data.user_address));
         end
      end
   end
endmodule
`default_nettype wire

>>> tb/tb_first_fit_block_allocator.sv
// tb_first_fit_block_allocator: drives allocate and free requests with random gaps and
// response stalls into the allocator and reports the verdict of ffba_checker
// depends on ffba_pkg, first_fit_block_allocator and ffba_checker
`timescale 1ns / 100ps
`default_nettype none
module tb_first_fit_block_allocator;
   import ffba_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count, pending_count;
   int      cycle_count = 0;
   logic [19:0] granted [$];

   always #6 clock = ~clock;

   first_fit_block_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   ffba_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // grants seen on the response side feed later frees
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_data.status == ST_OK
          && rsp_data.granted_address != 0)
         granted.push_back(rsp_data.granted_address);
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (cycle_count < 30000 || cycle_count > 60000) rsp_ready <= ($urandom_range(0, 9) < 7);
      else rsp_ready <= (gap_length() == 0);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 900000) begin
         $display("first_fit_block_allocator verification failed");
         $finish;
      end
   end

   // valid stays up at return; the next call or the caller drops it
   task automatic send_request(input logic kind, input logic [20:0] bytes,
                               input logic [19:0] addr);
      int g;
      g = gap_length();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_data.kind <= kind;
      req_data.request_bytes <= bytes;
      req_data.user_address <= addr;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_alloc(input logic [20:0] bytes);
      send_request(KIND_ALLOC, bytes, 20'($urandom));
   endtask

   task automatic send_free(input logic [19:0] addr);
      send_request(KIND_FREE, 21'($urandom), addr);
   endtask

   function automatic logic [20:0] pick_size();
      int p;
      p = $urandom_range(0, 99);
      if (p < 3) return 21'd0;
      if (p < 60) return 21'($urandom_range(1, 64));
      if (p < 90) return 21'($urandom_range(65, 5000));
      if (p < 98) return 21'($urandom_range(5000, 70000));
      return 21'($urandom);
   endfunction

   initial begin
      int idx, p;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed
      send_free(20'd24);
      send_free(20'd0);
      send_alloc(21'd0);
      send_alloc(21'd1);
      send_alloc(21'd8);
      send_alloc(21'd9);
      send_alloc(21'd4072);
      send_alloc(21'd4073);
      send_free(20'd24);
      send_free(20'd24);
      send_free(20'd56);
      send_free(20'd25);
      send_free(20'hFFFFF);
      send_alloc(21'd20);
      send_alloc(21'h1FFFFF);
      send_alloc(21'd1048576);
      send_alloc(21'd1000000);
      send_alloc(21'd3000);
      send_free(20'd0);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      // random: mostly allocs and frees of granted blocks, some noise
      for (int n = 0; n < 400; n++) begin
         p = $urandom_range(0, 99);
         if (p < 50) send_alloc(pick_size());
         else if (p < 88 && granted.size() != 0) begin
            idx = $urandom_range(0, granted.size() - 1);
            send_free(granted[idx]);
            if ($urandom_range(0, 3) != 0) granted.delete(idx);
         end else if (p < 94) send_free(20'($urandom));
         else send_free(20'($urandom_range(0, 40)));
      end
      // many small blocks to fill the slot table
      for (int n = 0; n < 80; n++) send_alloc(21'($urandom_range(1, 40)));
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (250) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("first_fit_block_allocator verification clean");
      else
         $display("first_fit_block_allocator verification failed");
      $finish;
   end
endmodule
`default_nettype wire
